>>> sv/stack_bytecode_to_x86_emitter_top_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the bytecode emitter
// Concurrent property wrappers, compiled out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef STACK_BYTECODE_TO_X86_EMITTER_TOP_DEFINES_SVH
`define STACK_BYTECODE_TO_X86_EMITTER_TOP_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication.
`define SBX_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sbx assertion failed");
// Next-cycle implication.
`define SBX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sbx assertion failed");
`else
`define SBX_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SBX_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> sv/sbx_pkg.sv
// ---------------------------------------------------------------------------
// sbx_pkg
// Shared types and codes of the bytecode to IA-32 emitter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sbx_pkg;

	// Bytecode opcodes that the decoder and emitter both look at.
	localparam logic [5:0] OP_LEA        = 6'd0;
	localparam logic [5:0] OP_IMM        = 6'd1;
	localparam logic [5:0] OP_JMP        = 6'd2;
	localparam logic [5:0] OP_JSR        = 6'd3;
	localparam logic [5:0] OP_BZ         = 6'd4;
	localparam logic [5:0] OP_BNZ        = 6'd5;
	localparam logic [5:0] OP_ENT        = 6'd6;
	localparam logic [5:0] OP_ADJ        = 6'd7;
	localparam logic [5:0] OP_TMPL_FIRST = 6'd8;
	localparam logic [5:0] OP_NAT_FIRST  = 6'd30;
	localparam logic [5:0] OP_LAST       = 6'd37;

	// Error codes carried on the result channel.
	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_FRAME_OFS = 3'd1;
	localparam logic [2:0] ERR_FRAME_SZ  = 3'd2;
	localparam logic [2:0] ERR_NO_ADJ    = 3'd3;
	localparam logic [2:0] ERR_BAD_OP    = 3'd4;
	localparam logic [2:0] ERR_FULL      = 3'd5;

	typedef struct packed {
		logic signed [31:0] bytecode_word;
	} sbx_word_t;

	typedef struct packed {
		logic [7:0]  code_byte;
		logic [17:0] byte_offset;
		logic        first_of_instruction;
		logic        last_of_run;
		logic [2:0]  error_code;
	} sbx_result_t;

	// One decoded instruction waiting to be serialized into bytes.
	typedef struct packed {
		logic [5:0]  op;
		logic [4:0]  last_idx;
		logic [2:0]  err;
		logic [31:0] imm;
		logic [31:0] rel;
	} sbx_job_t;

endpackage

>>> sv/sbx_stream_if.sv
// ---------------------------------------------------------------------------
// sbx_stream_if
// Valid/ready stream channel with a typed payload.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sbx_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> sv/sbx_decode.sv
// ---------------------------------------------------------------------------
// sbx_decode
// Input register, instruction decode, translator state and routine targets.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "stack_bytecode_to_x86_emitter_top_defines.svh"

module sbx_decode import sbx_pkg::*; #(
	parameter int CODE_BYTES = 262144,
	parameter int OFF_W      = 19
) (
	input  logic             clk,
	input  logic             arst_n,
	sbx_stream_if.sink       bytecode,
	input  logic             cfg_wr_en,
	input  logic [2:0]       cfg_index,
	input  logic [31:0]      cfg_data,
	output logic             job_push,
	output sbx_job_t         job,
	output logic [OFF_W-1:0] job_off,
	input  logic             job_ready
);

	localparam logic [2:0] PH_OPCODE  = 3'd0;
	localparam logic [2:0] PH_OPERAND = 3'd1;
	localparam logic [2:0] PH_ADJ     = 3'd2;
	localparam logic [2:0] PH_COUNT   = 3'd3;
	localparam logic [2:0] PH_HALT    = 3'd4;

	localparam logic [4:0] TMPL_LEN [22] = '{
		5'd4, 5'd2, 5'd3, 5'd3, 5'd3, 5'd1, 5'd3, 5'd3, 5'd3, 5'd9, 5'd9,
		5'd9, 5'd9, 5'd9, 5'd9, 5'd4, 5'd4, 5'd3, 5'd4, 5'd4, 5'd4, 5'd7
	};

	logic              valid_s1;
	logic [31:0]       word_s1;
	logic [2:0]        phase_q;
	logic [5:0]        held_q;
	logic [OFF_W-1:0]  off_q;
	logic [31:0]       target_q [8];

	logic              adv_s1;
	logic [2:0]        phase_d;
	logic [5:0]        held_d;
	logic              emits;
	logic [4:0]        len;
	logic [2:0]        err;
	logic              fits6;
	logic [31:0]       x4;
	logic [OFF_W:0]    end_off;
	logic              full;

	assign fits6 = (&word_s1[31:5]) | ~(|word_s1[31:5]);
	assign x4    = {word_s1[29:0], 2'b00};

	always_comb begin
		phase_d  = phase_q;
		held_d   = held_q;
		emits    = 1'b0;
		len      = 5'd1;
		err      = ERR_NONE;
		job.op   = OP_LEA;
		job.imm  = x4;
		job.rel  = target_q[3'(held_q - OP_NAT_FIRST)] - 32'(off_q) - 32'd29;
		case (phase_q)
			PH_OPCODE: begin
				if (word_s1 > 32'(OP_LAST)) begin
					err = ERR_BAD_OP;
				end else if (word_s1 <= 32'(OP_ADJ)) begin
					held_d  = word_s1[5:0];
					phase_d = PH_OPERAND;
				end else if (word_s1 >= 32'(OP_NAT_FIRST)) begin
					held_d  = word_s1[5:0];
					phase_d = PH_ADJ;
				end else begin
					emits  = 1'b1;
					job.op = word_s1[5:0];
					len    = TMPL_LEN[5'(word_s1[5:0] - OP_TMPL_FIRST)];
				end
			end
			PH_ADJ: begin
				if (word_s1 != 32'(OP_ADJ)) begin
					err = ERR_NO_ADJ;
				end else begin
					phase_d = PH_COUNT;
				end
			end
			PH_COUNT: begin
				phase_d = PH_OPCODE;
				emits   = 1'b1;
				job.op  = held_q;
				len     = 5'd31;
			end
			PH_OPERAND: begin
				phase_d = PH_OPCODE;
				emits   = 1'b1;
				job.op  = held_q;
				case (held_q)
					OP_LEA: begin
						len = 5'd3;
						if (!fits6) begin
							err = ERR_FRAME_OFS;
						end
					end
					OP_IMM: begin
						len     = 5'd5;
						job.imm = word_s1;
					end
					OP_JMP, OP_JSR: len = 5'd5;
					OP_BZ, OP_BNZ:  len = 5'd8;
					OP_ENT: begin
						len = (!word_s1[31] && word_s1 != 32'd0) ? 5'd6 : 5'd3;
						if (!fits6) begin
							err = ERR_FRAME_SZ;
						end
					end
					default: len = 5'd3;
				endcase
			end
			default: begin
				phase_d = PH_HALT;
			end
		endcase
	end

	assign end_off = {1'b0, off_q} + (OFF_W+1)'(len);
	assign full    = emits && (err == ERR_NONE) && (end_off > (OFF_W+1)'(CODE_BYTES));

	always_comb begin
		job.err      = err;
		job.last_idx = len - 5'd1;
		if (full) begin
			job.err = ERR_FULL;
		end
		if (job.err != ERR_NONE) begin
			job.last_idx = 5'd0;
		end
	end

	assign job_off  = off_q;
	assign job_push = adv_s1 && (emits || err != ERR_NONE);
	assign adv_s1   = valid_s1 && (!(emits || err != ERR_NONE) || job_ready);
	assign bytecode.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytecode.ready) begin
			valid_s1 <= bytecode.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytecode.ready && bytecode.valid) begin
			word_s1 <= bytecode.data.bytecode_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_OPCODE;
			held_q  <= 6'd0;
			off_q   <= '0;
			for (int i = 0; i < 8; i++) begin
				target_q[i] <= 32'd0;
			end
		end else begin
			if (cfg_wr_en) begin
				target_q[cfg_index] <= cfg_data;
			end
			if (adv_s1) begin
				held_d_apply: begin
					held_q <= held_d;
					if (job.err != ERR_NONE) begin
						phase_q <= PH_HALT;
					end else begin
						phase_q <= phase_d;
						if (emits) begin
							off_q <= end_off[OFF_W-1:0];
						end
					end
				end
			end
		end
	end

	`SBX_ASSERT_NEXT(a_halt_sticky, clk, arst_n, phase_q == PH_HALT, phase_q == PH_HALT)
	`SBX_ASSERT_IMP(a_no_job_halted, clk, arst_n, job_push, phase_q != PH_HALT)
	`SBX_ASSERT_NEXT(a_off_hold, clk, arst_n, !(job_push && job.err == ERR_NONE), $stable(off_q))

endmodule

>>> sv/sbx_emit.sv
// ---------------------------------------------------------------------------
// sbx_emit
// Holds one decoded instruction and sends its bytes through the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "stack_bytecode_to_x86_emitter_top_defines.svh"

module sbx_emit import sbx_pkg::*; #(
	parameter int OFF_W = 19
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             job_push,
	input  sbx_job_t         job,
	input  logic [OFF_W-1:0] job_off,
	output logic             job_ready,
	sbx_stream_if.source     code
);

	localparam logic [7:0] TMPL_BYTES [22][9] = '{
		'{8'h89, 8'hec, 8'h5d, 8'hc3, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h8b, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h0f, 8'hb6, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h59, 8'h89, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h59, 8'h88, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h50, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h59, 8'h09, 8'hc8, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h59, 8'h31, 8'hc8, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h59, 8'h21, 8'hc8, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h59, 8'h39, 8'hc1, 8'h0f, 8'h94, 8'hc0, 8'h66, 8'h98, 8'h98},
		'{8'h59, 8'h39, 8'hc1, 8'h0f, 8'h95, 8'hc0, 8'h66, 8'h98, 8'h98},
		'{8'h59, 8'h39, 8'hc1, 8'h0f, 8'h9c, 8'hc0, 8'h66, 8'h98, 8'h98},
		'{8'h59, 8'h39, 8'hc1, 8'h0f, 8'h9f, 8'hc0, 8'h66, 8'h98, 8'h98},
		'{8'h59, 8'h39, 8'hc1, 8'h0f, 8'h9e, 8'hc0, 8'h66, 8'h98, 8'h98},
		'{8'h59, 8'h39, 8'hc1, 8'h0f, 8'h9d, 8'hc0, 8'h66, 8'h98, 8'h98},
		'{8'h59, 8'h91, 8'hd3, 8'he0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h59, 8'h91, 8'hd3, 8'he8, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h59, 8'h01, 8'hc8, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h59, 8'h91, 8'h29, 8'hc8, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h59, 8'h0f, 8'haf, 8'hc1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h59, 8'h91, 8'hf7, 8'hf9, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h59, 8'h91, 8'h31, 8'hd2, 8'hf7, 8'hf9, 8'h92, 8'h00, 8'h00}
	};

	localparam logic [7:0] THUNK_MID [20] = '{
		8'h89, 8'he6, 8'h29, 8'hce, 8'hc1, 8'he9, 8'h02, 8'h83, 8'he6, 8'hf0,
		8'h5a, 8'h89, 8'h54, 8'h8e, 8'hfc, 8'he2, 8'hf9, 8'h87, 8'hf4, 8'he8
	};

	// Byte k of the instruction described by j.
	function automatic logic [7:0] job_byte(sbx_job_t j, logic [4:0] k);
		logic [7:0] b;
		logic [7:0] imm_b;
		logic [7:0] rel_b;
		imm_b = 8'(j.imm >> {2'(k - 5'd1), 3'b000});
		rel_b = 8'(j.rel >> {2'(k - 5'd25), 3'b000});
		b     = 8'h00;
		case (j.op)
			OP_LEA: b = (k == 5'd0) ? 8'h8d : (k == 5'd1) ? 8'h45 : j.imm[7:0];
			OP_IMM: b = (k == 5'd0) ? 8'hb8 : imm_b;
			OP_JMP: b = (k == 5'd0) ? 8'he9 : 8'h00;
			OP_JSR: b = (k == 5'd0) ? 8'he8 : 8'h00;
			OP_BZ, OP_BNZ: begin
				if (k == 5'd0) begin
					b = 8'h85;
				end else if (k == 5'd1) begin
					b = 8'hc0;
				end else if (k == 5'd2) begin
					b = 8'h0f;
				end else if (k == 5'd3) begin
					b = (j.op == OP_BZ) ? 8'h84 : 8'h85;
				end
			end
			OP_ENT: begin
				if (k == 5'd0) begin
					b = 8'h55;
				end else if (k == 5'd1) begin
					b = 8'h89;
				end else if (k == 5'd2) begin
					b = 8'he5;
				end else if (k == 5'd3) begin
					b = 8'h83;
				end else if (k == 5'd4) begin
					b = 8'hec;
				end else begin
					b = j.imm[7:0];
				end
			end
			OP_ADJ: b = (k == 5'd0) ? 8'h83 : (k == 5'd1) ? 8'hc4 : j.imm[7:0];
			default: begin
				if (j.op >= OP_NAT_FIRST) begin
					if (k == 5'd0) begin
						b = 8'hb9;
					end else if (k inside {[5'd1:5'd4]}) begin
						b = imm_b;
					end else if (k inside {[5'd5:5'd24]}) begin
						b = THUNK_MID[5'(k - 5'd5)];
					end else if (k inside {[5'd25:5'd28]}) begin
						b = rel_b;
					end else if (k == 5'd29) begin
						b = 8'h87;
					end else begin
						b = 8'hf4;
					end
				end else begin
					b = TMPL_BYTES[5'(j.op - OP_TMPL_FIRST)][4'(k)];
				end
			end
		endcase
		if (j.err != ERR_NONE) begin
			b = 8'h00;
		end
		return b;
	endfunction

	logic              valid_s2;
	sbx_job_t          job_s2;
	logic [OFF_W-1:0]  off_s2;
	logic [4:0]        idx_q;
	logic              ovalid_q;
	sbx_result_t       res_q;

	logic              out_load;
	logic              last_byte;
	logic [OFF_W-1:0]  off_sum;
	logic [OFF_W+17:0] off_ext;

	assign out_load  = valid_s2 && (!ovalid_q || code.ready);
	assign last_byte = idx_q == job_s2.last_idx;
	assign job_ready = !valid_s2 || (out_load && last_byte);
	assign off_sum   = off_s2 + OFF_W'(idx_q);
	assign off_ext   = {18'd0, off_sum};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= 5'd0;
			ovalid_q <= 1'b0;
		end else begin
			if (job_push) begin
				valid_s2 <= 1'b1;
				idx_q    <= 5'd0;
			end else if (out_load) begin
				if (last_byte) begin
					valid_s2 <= 1'b0;
					idx_q    <= 5'd0;
				end else begin
					idx_q <= idx_q + 5'd1;
				end
			end
			if (out_load) begin
				ovalid_q <= 1'b1;
			end else if (code.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_push) begin
			job_s2 <= job;
			off_s2 <= job_off;
		end
		if (out_load) begin
			res_q.code_byte            <= job_byte(job_s2, idx_q);
			res_q.byte_offset          <= off_ext[17:0];
			res_q.first_of_instruction <= (idx_q == 5'd0) && (job_s2.err == ERR_NONE);
			res_q.last_of_run          <= last_byte;
			res_q.error_code           <= job_s2.err;
		end
	end

	assign code.valid = ovalid_q;
	assign code.data  = res_q;

	`SBX_ASSERT_IMP(a_idx_bound, clk, arst_n, valid_s2, idx_q <= job_s2.last_idx)
	`SBX_ASSERT_IMP(a_err_single, clk, arst_n, valid_s2 && job_s2.err != ERR_NONE, job_s2.last_idx == 5'd0)
	`SBX_ASSERT_NEXT(a_job_retire, clk, arst_n, out_load && last_byte && !job_push, !valid_s2)

endmodule

>>> sv/stack_bytecode_to_x86_emitter_top.sv
// ---------------------------------------------------------------------------
// stack_bytecode_to_x86_emitter_top
// Translates stack-machine bytecode words into IA-32 machine code bytes.
// ---------------------------------------------------------------------------
// Each bytecode word is taken in one transaction on the bytecode channel and
// the block answers with zero or more byte transactions on the code channel,
// one machine code byte each with its buffer offset, in program order. Words
// that only hold an opcode for its operand, or the ADJ word after a native
// call, produce nothing. The path is three registers deep: the accepted word
// sits in an input register, is decoded there against the translator state
// into one instruction record, and that record is then played out one byte
// per cycle, while the code channel is ready, through the output register.
// A word therefore enters in the cycle after the previous one whenever the
// byte player is free, and an instruction keeps the byte player busy until
// its last byte has gone into the output register of the single byte-wide
// output port. While the last byte of one instruction waits to be taken,
// the next word can already be accepted and decoded. Any error (frame
// range, missing ADJ, bad opcode, code buffer full) yields one transaction
// with code byte zero and the error code, after which words are still
// accepted but dropped until reset. The eight routine target registers
// are written through the plain configuration port and should change only
// while the block is idle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module stack_bytecode_to_x86_emitter_top import sbx_pkg::*; #(
	parameter int CODE_BYTES = 262144
) (
	input  logic         clk,
	input  logic         arst_n,
	sbx_stream_if.sink   bytecode,
	sbx_stream_if.source code,
	input  logic         cfg_wr_en,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	// The emit offset has to reach CODE_BYTES itself.
	localparam int OFF_W = $clog2(CODE_BYTES + 1);

	logic             job_push;
	logic             job_ready;
	sbx_job_t         job;
	logic [OFF_W-1:0] job_off;

	// Decode stage: input register, state machine and the target registers.
	sbx_decode #(
		.CODE_BYTES (CODE_BYTES),
		.OFF_W      (OFF_W)
	) u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.bytecode  (bytecode),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.job_push  (job_push),
		.job       (job),
		.job_off   (job_off),
		.job_ready (job_ready)
	);

	// Byte player: one instruction record, a byte counter and the output register.
	sbx_emit #(
		.OFF_W (OFF_W)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_push  (job_push),
		.job       (job),
		.job_off   (job_off),
		.job_ready (job_ready),
		.code      (code)
	);

endmodule
